// ===== rtl/sc2a_pkg.sv =====
// Shared types, scancode constants and the set-1 US-layout character tables.
// Used by the controller, the datapath and the top level of the translator.
package sc2a_pkg;

    localparam int MAPPED_CODES = 58;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;

    localparam logic CMD_SCANCODE = 1'b0;
    localparam logic CMD_READ     = 1'b1;

    // Unshifted column, codes 0 to 57.
    localparam logic [6:0] PLAIN_COL [0:MAPPED_CODES-1] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };

    // Shifted column, codes 0 to 57.
    localparam logic [6:0] SHIFTED_COL [0:MAPPED_CODES-1] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };

    // Controller to datapath commands.
    typedef struct packed {
        logic push;   // scancode beat accepted
        logic rd;     // read beat accepted: fetch the head entry
        logic load;   // load the output register, pop if not empty
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic empty;
    } t_dp_status;

    // Translate a make code; zero means no character.
    function automatic logic [6:0] f_lookup(input logic [7:0] code, input logic shift);
        logic [6:0] ch;
        ch = 7'h00;
        if (code < 8'(MAPPED_CODES)) begin
            ch = shift ? SHIFTED_COL[code[5:0]] : PLAIN_COL[code[5:0]];
        end
        return ch;
    endfunction

endpackage

// ===== rtl/sc2a_ctrl.sv =====
// Controller of the scancode translator: input/output handshakes and read sequencing.
// Depends on sc2a_pkg for the command and status structs.
module sc2a_ctrl
    import sc2a_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_command,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;
    logic   w_is_read;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_is_read   = (i_in_command == CMD_READ);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd.push = w_accept && !w_is_read;
        o_cmd.rd   = w_accept && w_is_read;
        o_cmd.load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_is_read) begin
                    // empty read with a free slot answers at once
                    if (i_status.empty && w_slot_free) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (w_slot_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_out_valid)
        else $error("loaded result not presented");

    a_read_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rd && !o_cmd.load) |=> (r_state == S_READ))
        else $error("pending read lost");
`endif

endmodule

// ===== rtl/sc2a_dp.sv =====
// Datapath of the scancode translator: shift flag, table lookup, character ring and output register.
// Depends on sc2a_pkg for the tables, scancode constants and command/status structs.
module sc2a_dp
    import sc2a_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_scancode,
    output t_dp_status o_status,
    output logic [6:0] o_character,
    output logic       o_was_empty
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);

    logic [6:0]       r_mem [FIFO_DEPTH];
    logic [6:0]       r_mem_q;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic             r_shift, n_shift;
    logic [PTR_W-1:0] w_wr_next;
    logic [PTR_W-1:0] w_rd_next;
    logic [6:0]       w_char;
    logic             w_empty;
    logic             w_full;
    logic             w_wr_en;

    assign w_wr_next = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_next = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
    assign w_empty   = (r_wr_ptr == r_rd_ptr);
    assign w_full    = (w_wr_next == r_rd_ptr);
    assign w_char    = f_lookup(i_scancode, r_shift);
    // drop break codes, unmapped codes and characters that find the ring full
    assign w_wr_en   = i_cmd.push && !i_scancode[7] && (w_char != 7'h00) && !w_full;

    assign o_status.empty = w_empty;

    always_comb begin
        n_shift = r_shift;
        if (i_cmd.push) begin
            unique case (i_scancode) inside
                SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   n_shift = 1'b1;
                SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: n_shift = 1'b0;
                default:                          n_shift = r_shift;
            endcase
        end
    end

    always_comb begin
        n_wr_ptr = w_wr_en ? w_wr_next : r_wr_ptr;
        n_rd_ptr = (i_cmd.load && !w_empty) ? w_rd_next : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_shift  <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_shift  <= n_shift;
        end
    end

    // Character ring with registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr_ptr] <= w_char;
        end
        if (i_cmd.rd) begin
            r_mem_q <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_character <= w_empty ? 7'h00 : r_mem_q;
            o_was_empty <= w_empty;
        end
    end

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr <= LAST_IDX) && (r_rd_ptr <= LAST_IDX))
        else $error("ring pointer out of range");

    a_write_never_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_wr_ptr != r_rd_ptr))
        else $error("write overran the read pointer");

    a_empty_read_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && w_empty) |=> $stable(r_rd_ptr))
        else $error("read pointer moved on an empty read");
`endif

endmodule

// ===== rtl/scancode_to_ascii_fifo.sv =====
// Set-1 scancode to ASCII translator with a character ring; joins sc2a_ctrl and sc2a_dp.
// Scancode beat: one per cycle while the input is not stalled, no result beat. Read beat:
// the head is fetched into the ring's read-port register, then loaded into the result
// register once the output slot is free; an empty read with a free slot loads at once.
// Input stalls while a read is pending. Reset (i_rst_n low, synchronous) clears pointers,
// shift flag and output valid; ring contents stay, and unwritten entries never reach the output.
module scancode_to_ascii_fifo
    import sc2a_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_in_command,
    input  logic [7:0] i_in_scancode,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_character,
    output logic       o_was_empty
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Handshakes and the read sequence: a read beat fetches the ring head, then
    // waits for a free output slot before loading and, if the ring is not empty, popping.
    sc2a_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_command),
        .i_out_stall  (i_out_stall),
        .i_status     (w_status),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_cmd        (w_cmd)
    );

    // Shift tracking, table lookup, ring storage and the result register.
    // The ring keeps one entry spare to tell full from empty.
    sc2a_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_scancode  (i_in_scancode),
        .o_status    (w_status),
        .o_character (o_character),
        .o_was_empty (o_was_empty)
    );

endmodule

// ===== sim/scancode_to_ascii_fifo_test.sv =====
// Self-checking bench for scancode_to_ascii_fifo: drives scancode and read beats,
// tracks the expected key translation and character ring in-bench, checks every result.
// Depends on rtl/sc2a_pkg.sv and rtl/scancode_to_ascii_fifo.sv.
`timescale 1ns / 1ps

module scancode_to_ascii_fifo_test;
    import sc2a_pkg::*;

    localparam int RING_DEPTH       = 256;
    localparam int LONG_HOLD_CYCLES = 400;

    // Directed key codes (set 1, make side unless marked as a break).
    localparam logic [7:0] KEY_1      = 8'h02;
    localparam logic [7:0] KEY_Q      = 8'h10;
    localparam logic [7:0] KEY_P      = 8'h19;
    localparam logic [7:0] KEY_CTRL   = 8'h1D;  // table holds no character
    localparam logic [7:0] KEY_A      = 8'h1E;
    localparam logic [7:0] KEY_SPACE  = 8'h39;  // last mapped code
    localparam logic [7:0] KEY_CAPS   = 8'h3A;  // first code past the table
    localparam logic [7:0] KEY_A_UP   = 8'h9E;  // break of a plain key

    // US layout, unshifted and shifted, codes 0 to 57.
    localparam logic [6:0] US_PLAIN [0:57] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };
    localparam logic [6:0] US_SHIFTED [0:57] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct packed {
        logic [6:0] ch;
        logic       was_empty;
    } t_read_reply;

    // DUT inputs start at known values.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       i_in_command  = CMD_SCANCODE;
    logic [7:0] i_in_scancode = 8'h00;
    logic       i_out_stall   = 1'b0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [6:0] o_character;
    logic       o_was_empty;

    // Expected translator state: characters typed and not yet read, shift flag.
    logic [6:0]  typed_chars[$];
    logic        shift_down = 1'b0;
    t_read_reply pending_replies[$];

    int error_count   = 0;
    bit pace_on       = 1'b1;  // random gaps on both sides when set
    int hold_off_asks = 0;     // bump to request one long result hold-off

    scancode_to_ascii_fifo #(
        .FIFO_DEPTH(RING_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_command (i_in_command),
        .i_in_scancode(i_in_scancode),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_character  (o_character),
        .o_was_empty  (o_was_empty)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Apply one accepted input beat to the expected state. A read beat always
    // yields one reply; a scancode beat never does.
    function automatic void decode_key_beat(input logic cmd, input logic [7:0] code);
        logic [6:0]  ch;
        t_read_reply reply;
        if (cmd == CMD_READ) begin
            // Empty ring: zero character with the empty flag, pointers stay.
            if (typed_chars.size() == 0) begin
                reply.ch        = 7'h00;
                reply.was_empty = 1'b1;
            end else begin
                reply.ch        = typed_chars.pop_front();
                reply.was_empty = 1'b0;
            end
            pending_replies.push_back(reply);
        end else if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
            shift_down = 1'b1;
        end else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
            shift_down = 1'b0;
        end else if (!code[7] && code < 8'(MAPPED_CODES)) begin
            ch = shift_down ? US_SHIFTED[code[5:0]] : US_PLAIN[code[5:0]];
            // Drop zero entries, and drop silently once the ring holds depth-1.
            if (ch != 7'h00 && typed_chars.size() < RING_DEPTH - 1) begin
                typed_chars.push_back(ch);
            end
        end
    endfunction

    // Sample both channels at the edge: check the result beat against the oldest
    // reply, then advance the expected state with the input beat.
    always @(posedge i_clk) begin : check_and_track
        t_read_reply want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: result beat with no read pending, character %h empty %b",
                             $time, o_character, o_was_empty);
                    error_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (o_character !== want.ch) begin
                        $display("%0t: character mismatch, expected %h, actual %h",
                                 $time, want.ch, o_character);
                        error_count++;
                    end
                    if (o_was_empty !== want.was_empty) begin
                        $display("%0t: was_empty mismatch, expected %b, actual %b",
                                 $time, want.was_empty, o_was_empty);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                decode_key_beat(i_in_command, i_in_scancode);
            end
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (!pace_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stall stretches, solid ready stretches when pacing is
    // off, and one long hold-off per request, counted here in cycles.
    initial begin : result_stall_drive
        int hold_off_seen;
        int stretch;
        logic stall_val;
        hold_off_seen = 0;
        forever begin
            if (hold_off_asks != hold_off_seen) begin
                hold_off_seen = hold_off_asks;
                stall_val     = 1'b1;
                stretch       = LONG_HOLD_CYCLES;
            end else if (!pace_on) begin
                stall_val = 1'b0;
                stretch   = 16;
            end else begin
                stall_val = ($urandom_range(0, 2) == 0);
                stretch   = stall_val ? pick_pause() + 1 : $urandom_range(1, 12);
            end
            i_out_stall <= stall_val;
            repeat (stretch) @(posedge i_clk);
        end
    end

    // Offer one beat after a random gap and hold it until it is taken.
    task automatic send_beat(input logic cmd, input logic [7:0] code);
        int pause;
        pause = pick_pause();
        if (pause > 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_command  <= cmd;
        i_in_scancode <= code;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic send_read();
        send_beat(CMD_READ, 8'($urandom_range(0, 255)));
    endtask

    // Empty read, both shift keys, a plain break under shift, unmapped and
    // zero-table codes, other breaks; then read everything back past empty.
    task automatic test_shift_and_table();
        send_beat(CMD_READ, 8'hFF);
        send_beat(CMD_SCANCODE, KEY_1);
        send_beat(CMD_SCANCODE, SC_LSHIFT_MAKE);
        send_beat(CMD_SCANCODE, KEY_1);
        send_beat(CMD_SCANCODE, KEY_A_UP);       // must not release shift
        send_beat(CMD_SCANCODE, KEY_A);
        send_beat(CMD_SCANCODE, SC_LSHIFT_BREAK);
        send_beat(CMD_SCANCODE, KEY_A);
        send_beat(CMD_SCANCODE, SC_RSHIFT_MAKE);
        send_beat(CMD_SCANCODE, KEY_Q);
        send_beat(CMD_SCANCODE, SC_RSHIFT_BREAK);
        send_beat(CMD_SCANCODE, KEY_SPACE);
        send_beat(CMD_SCANCODE, KEY_CAPS);
        send_beat(CMD_SCANCODE, 8'h7F);
        send_beat(CMD_SCANCODE, 8'h00);
        send_beat(CMD_SCANCODE, KEY_CTRL);
        send_beat(CMD_SCANCODE, 8'h80);
        send_beat(CMD_SCANCODE, 8'hFF);
        repeat (7) send_beat(CMD_READ, 8'h00);
    endtask

    // Every byte value in both shift states; read after each mapped code and
    // once more at the end of the column, so any stray character shows up.
    // Restore the column's shift state whenever the sweep hits a shift code.
    task automatic test_code_sweep();
        int col;
        int code;
        logic [7:0] col_code;
        for (col = 0; col < 2; col++) begin
            col_code = (col == 0) ? SC_RSHIFT_BREAK : SC_RSHIFT_MAKE;
            send_beat(CMD_SCANCODE, col_code);
            for (code = 0; code < 256; code++) begin
                send_beat(CMD_SCANCODE, 8'(code));
                if (8'(code) == SC_LSHIFT_MAKE || 8'(code) == SC_RSHIFT_MAKE ||
                    8'(code) == SC_LSHIFT_BREAK || 8'(code) == SC_RSHIFT_BREAK) begin
                    send_beat(CMD_SCANCODE, col_code);
                end
                if (code < MAPPED_CODES) begin
                    send_read();
                end
            end
            send_read();
        end
    endtask

    // Overfill the ring: the extra characters drop, then drain it past empty.
    task automatic test_full_ring();
        send_beat(CMD_SCANCODE, SC_LSHIFT_BREAK);
        repeat (RING_DEPTH + 16) send_beat(CMD_SCANCODE, 8'($urandom_range(KEY_Q, KEY_P)));
        repeat (RING_DEPTH + 4) send_read();
    endtask

    // Hold the result side off for a long stretch while beats keep coming, so
    // the held result stalls the input.
    task automatic test_back_pressure();
        hold_off_asks++;
        repeat (90) begin
            if ($urandom_range(0, 2) == 0) send_read();
            else send_beat(CMD_SCANCODE, 8'($urandom_range(0, MAPPED_CODES - 1)));
        end
    endtask

    // Typing traffic: mostly keys and shifted words, plus reads at the given
    // rate and some stray bytes.
    task automatic test_random_typing(input int n_items, input int read_pct);
        int sent;
        int r;
        int keys;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < read_pct) begin
                send_read();
                sent++;
            end else if (r < read_pct + 10) begin
                // shifted word: either shift down, a few keys, either shift up
                keys = $urandom_range(1, 5);
                send_beat(CMD_SCANCODE, $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE);
                repeat (keys) send_beat(CMD_SCANCODE, 8'($urandom_range(0, MAPPED_CODES - 1)));
                send_beat(CMD_SCANCODE,
                          $urandom_range(0, 1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK);
                sent += keys + 2;
            end else if (r < read_pct + 16) begin
                send_beat(CMD_SCANCODE, 8'($urandom_range(0, 255)));
                sent++;
            end else begin
                send_beat(CMD_SCANCODE, 8'($urandom_range(0, MAPPED_CODES - 1)));
                sent++;
            end
        end
    endtask

    initial begin : run_tests
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_shift_and_table();
        test_code_sweep();
        test_full_ring();
        test_back_pressure();
        test_random_typing(50, 50);
        test_random_typing(50, 20);    // ring tends to grow
        test_random_typing(50, 75);    // ring tends to drain, many empty reads
        pace_on = 1'b0;                // solid stretch, no idling on either side
        test_random_typing(50, 40);
        pace_on = 1'b1;
        test_random_typing(50, 50);

        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        // let any stray result beat surface
        repeat (16) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
